>>> rtl/c_like_source_tokenizer_core_macros.svh
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Small wrappers for the concurrent assertions of the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef C_LIKE_SOURCE_TOKENIZER_CORE_MACROS_SVH
`define C_LIKE_SOURCE_TOKENIZER_CORE_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define CLT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks a property that must hold on every clock edge outside reset.
`define CLT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`endif

>>> rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Token kinds, scanner modes, widths and the request structures.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned KindW = 6;
  localparam int unsigned LineW = 24;
  localparam int unsigned ColW  = 16;
  localparam int unsigned OffW  = 32;
  localparam int unsigned LenW  = 16;

  localparam logic [KindW-1:0] KIdent    = 6'd0;
  localparam logic [KindW-1:0] KIntLit   = 6'd8;
  localparam logic [KindW-1:0] KFloatLit = 6'd9;
  localparam logic [KindW-1:0] KString   = 6'd10;
  localparam logic [KindW-1:0] KDivide   = 6'd22;
  localparam logic [KindW-1:0] KUnknown  = 6'd34;
  localparam logic [KindW-1:0] KEnd      = 6'd35;

  // Scanner modes.
  localparam logic [3:0] MIdle     = 4'd0;
  localparam logic [3:0] MIdent    = 4'd1;
  localparam logic [3:0] MInt      = 4'd2;
  localparam logic [3:0] MIntDot   = 4'd3;
  localparam logic [3:0] MFloat    = 4'd4;
  localparam logic [3:0] MString   = 4'd5;
  localparam logic [3:0] MSlash    = 4'd6;
  localparam logic [3:0] MLComment = 4'd7;
  localparam logic [3:0] MBComment = 4'd8;
  localparam logic [3:0] MBStar    = 4'd9;
  localparam logic [3:0] MOp2      = 4'd10;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  column;
    logic [OffW-1:0]  offset;
    logic [LenW-1:0]  length;
    logic             last;
  } token_t;

  // Up to three tokens caused by one request.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
    token_t     tok2;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [LenW-1:0] sat_len(input logic [LenW-1:0] a,
                                              input logic [1:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {{(LenW-1){1'b0}}, b};
    return s[LenW] ? {LenW{1'b1}} : s[LenW-1:0];
  endfunction

  function automatic logic [ColW-1:0] sat_col(input logic [ColW-1:0] a,
                                              input logic [LenW-1:0] b);
    logic [ColW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ColW] ? {ColW{1'b1}} : s[ColW-1:0];
  endfunction

  function automatic logic [OffW-1:0] sat_off(input logic [OffW-1:0] a,
                                              input logic [LenW-1:0] b);
    logic [OffW:0] s;
    s = {1'b0, a} + {{(OffW-LenW+1){1'b0}}, b};
    return s[OffW] ? {OffW{1'b1}} : s[OffW-1:0];
  endfunction

endpackage

>>> rtl/c_like_source_tokenizer_core.sv
// A token is registered into the token queue with the byte or end request that completes it.
// Throughput: one request per cycle; a request makes up to three tokens, one leaves a cycle while out_ready_i is high.
// The eight-entry token queue sets the rate: input stalls while it has under three free slots.
// Reset: asynchronous, active low; scanner at line 1, column 1, offset 0, queue empty.
// An end request also returns the scanner position to that reset state.
// ----------------------------------------------------------------------------
// C-like source tokenizer
// Streaming lexer: a scanner front end feeding a token queue back end.
// ----------------------------------------------------------------------------
module c_like_source_tokenizer_core import clt_pkg::*; #(
  parameter int unsigned MAX_KEYWORD_LEN = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [7:0]       byte_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KindW-1:0] token_kind_o,
  output logic [LineW-1:0] start_line_o,
  output logic [ColW-1:0]  start_column_o,
  output logic [OffW-1:0]  start_offset_o,
  output logic [LenW-1:0]  token_length_o,
  output logic             last_o
);

  bundle_t bundle;
  token_t  tok;
  logic    accept;

  // A request is taken whenever the queue can absorb its worst-case burst.
  assign accept = in_valid_i && in_ready_o;

  clt_scanner #(.MaxKeywordLen(MAX_KEYWORD_LEN)) u_scanner (
    .clk_i, .rst_ni,
    .valid_i (accept),
    .op_i,
    .byte_i  (byte_in_i),
    .bundle_o(bundle)
  );

  // The queue decouples the scanner from a stalled consumer.
  clt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (accept),
    .bundle_i(bundle),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .token_o (tok),
    .pop_i   (out_ready_i)
  );

  assign token_kind_o   = tok.kind;
  assign start_line_o   = tok.line;
  assign start_column_o = tok.column;
  assign start_offset_o = tok.offset;
  assign token_length_o = tok.length;
  assign last_o         = tok.last;

endmodule

>>> rtl/clt_scanner.sv
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Classifies one byte per cycle while valid_i holds; forms tokens it ends.
// ----------------------------------------------------------------------------
module clt_scanner import clt_pkg::*; #(
  parameter int unsigned MaxKeywordLen = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic       op_i,
  input  logic [7:0] byte_i,
  output bundle_t    bundle_o
);

  localparam int unsigned PrefW = 8 * MaxKeywordLen;

  logic [3:0]       mode_q, mode_d;
  logic [2:0]       pend_q, pend_d;
  logic [LineW-1:0] line_q, line_d, sline_q, sline_d;
  logic [ColW-1:0]  col_q, col_d, scol_q, scol_d;
  logic [OffW-1:0]  off_q, off_d, soff_q, soff_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [PrefW-1:0] pref_q, pref_d;

  function automatic logic [PrefW-1:0] kw(input logic [47:0] s);
    return PrefW'(s);
  endfunction

  function automatic logic [KindW-1:0] op_double(input logic [2:0] p);
    case (p)
      3'd1: return 6'd27;
      3'd2: return 6'd29;
      3'd3: return 6'd31;
      3'd4: return 6'd32;
      3'd5: return 6'd33;
      default: return 6'd25;
    endcase
  endfunction

  function automatic logic [KindW-1:0] op_single(input logic [2:0] p);
    case (p)
      3'd1: return 6'd26;
      3'd2: return 6'd28;
      3'd3: return 6'd30;
      3'd4, 3'd5: return KUnknown;
      default: return 6'd24;
    endcase
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    case (p)
      3'd4: return 8'h26;
      3'd5: return 8'h7c;
      default: return 8'h3d;
    endcase
  endfunction

  logic [KindW-1:0] id_kind;
  always_comb begin
    id_kind = KIdent;
    if (cnt_q == 16'd3 && pref_q == kw(48'h696e74)) id_kind = 6'd1;
    if (cnt_q == 16'd5 && pref_q == kw(48'h666c6f6174)) id_kind = 6'd2;
    if (cnt_q == 16'd2 && pref_q == kw(48'h6966)) id_kind = 6'd3;
    if (cnt_q == 16'd4 && pref_q == kw(48'h656c7365)) id_kind = 6'd4;
    if (cnt_q == 16'd5 && pref_q == kw(48'h7768696c65)) id_kind = 6'd5;
    if (cnt_q == 16'd6 && pref_q == kw(48'h72657475726e)) id_kind = 6'd6;
    if (cnt_q == 16'd4 && pref_q == kw(48'h766f6964)) id_kind = 6'd7;
  end

  token_t toks [3];
  logic [1:0] n;

  always_comb begin
    logic       rescan;
    logic [7:0] c;
    logic [2:0] p;
    token_t     t;
    c = byte_i;
    p = (pend_q < 3'd6) ? pend_q : 3'd0;
    rescan = 1'b0;
    n = 2'd0;
    for (int i = 0; i < 3; i++) toks[i] = '0;
    mode_d = mode_q; pend_d = pend_q;
    line_d = line_q; col_d = col_q; off_d = off_q;
    sline_d = sline_q; scol_d = scol_q; soff_d = soff_q;
    cnt_d = cnt_q; pref_d = pref_q;
    t = '0;
    t.line = sline_q; t.column = scol_q; t.offset = soff_q; t.length = cnt_q;

    if (valid_i && op_i) begin
      unique case (mode_q)
        MIdent: begin t.kind = id_kind; toks[0] = t; n = 2'd1; end
        MInt: begin t.kind = KIntLit; toks[0] = t; n = 2'd1; end
        MIntDot: begin
          t.kind = KIntLit; toks[0] = t;
          t.kind = KUnknown; t.column = sat_col(scol_q, cnt_q);
          t.offset = sat_off(soff_q, cnt_q); t.length = 16'd1; toks[1] = t;
          n = 2'd2;
        end
        MFloat: begin t.kind = KFloatLit; toks[0] = t; n = 2'd1; end
        MString: begin
          t.kind = KUnknown; t.length = sat_len(cnt_q, 2'd1); toks[0] = t; n = 2'd1;
        end
        MSlash: begin t.kind = KDivide; toks[0] = t; n = 2'd1; end
        MOp2: begin t.kind = op_single(p); toks[0] = t; n = 2'd1; end
        default: ;
      endcase
      t = '0;
      t.kind = KEnd; t.line = line_q; t.column = col_q; t.offset = off_q;
      toks[n] = t;
      n = n + 2'd1;
      mode_d = MIdle; pend_d = '0; line_d = 24'd1; col_d = 16'd1; off_d = '0;
      sline_d = 24'd1; scol_d = 16'd1; soff_d = '0; cnt_d = '0; pref_d = '0;
    end else if (valid_i) begin
      unique case (mode_q)
        MIdent:
          if (is_alpha(c) || is_digit(c) || c == 8'h5f) begin
            if (cnt_q < LenW'(MaxKeywordLen)) pref_d = {pref_q[PrefW-9:0], c};
            cnt_d = sat_len(cnt_q, 2'd1);
          end else begin
            t.kind = id_kind; toks[0] = t; n = 2'd1; rescan = 1'b1;
          end
        MInt:
          if (is_digit(c)) cnt_d = sat_len(cnt_q, 2'd1);
          else if (c == 8'h2e) mode_d = MIntDot;
          else begin t.kind = KIntLit; toks[0] = t; n = 2'd1; rescan = 1'b1; end
        MIntDot:
          if (is_digit(c)) begin
            cnt_d = sat_len(cnt_q, 2'd2); mode_d = MFloat;
          end else begin
            t.kind = KIntLit; toks[0] = t;
            t.kind = KUnknown; t.column = sat_col(scol_q, cnt_q);
            t.offset = sat_off(soff_q, cnt_q); t.length = 16'd1; toks[1] = t;
            n = 2'd2; rescan = 1'b1;
          end
        MFloat:
          if (is_digit(c)) cnt_d = sat_len(cnt_q, 2'd1);
          else begin t.kind = KFloatLit; toks[0] = t; n = 2'd1; rescan = 1'b1; end
        MString:
          if (c == 8'h22) begin
            t.kind = KString; t.offset = sat_off(soff_q, 16'd1);
            toks[0] = t; n = 2'd1; mode_d = MIdle;
          end else cnt_d = sat_len(cnt_q, 2'd1);
        MSlash:
          if (c == 8'h2f) mode_d = MLComment;
          else if (c == 8'h2a) mode_d = MBComment;
          else begin t.kind = KDivide; toks[0] = t; n = 2'd1; rescan = 1'b1; end
        MLComment: if (c == 8'h0a) mode_d = MIdle;
        MBComment: if (c == 8'h2a) mode_d = MBStar;
        MBStar:
          if (c == 8'h2f) mode_d = MIdle;
          else if (c != 8'h2a) mode_d = MBComment;
        MOp2:
          if (c == op_second(p)) begin
            t.kind = op_double(p); t.length = 16'd2; toks[0] = t; n = 2'd1;
            mode_d = MIdle;
          end else begin
            t.kind = op_single(p); toks[0] = t; n = 2'd1; rescan = 1'b1;
          end
        default: rescan = 1'b1;
      endcase

      // Any non-blank byte that ends a token or comes while idle opens one.
      if (rescan) begin
        mode_d = MIdle;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
        end else if (is_alpha(c) || c == 8'h5f || is_digit(c) || c == 8'h22 ||
                     c == 8'h2f || c == 8'h3d || c == 8'h21 || c == 8'h3c ||
                     c == 8'h3e || c == 8'h26 || c == 8'h7c) begin
          sline_d = line_q; scol_d = col_q; soff_d = off_q; cnt_d = 16'd1;
          if (is_alpha(c) || c == 8'h5f) begin
            mode_d = MIdent; pref_d = PrefW'(c);
          end else if (is_digit(c)) mode_d = MInt;
          else if (c == 8'h22) begin mode_d = MString; cnt_d = '0; end
          else if (c == 8'h2f) mode_d = MSlash;
          else begin
            mode_d = MOp2;
            case (c)
              8'h21: pend_d = 3'd1;
              8'h3c: pend_d = 3'd2;
              8'h3e: pend_d = 3'd3;
              8'h26: pend_d = 3'd4;
              8'h7c: pend_d = 3'd5;
              default: pend_d = 3'd0;
            endcase
          end
        end else begin
          t = '0;
          t.line = line_q; t.column = col_q; t.offset = off_q; t.length = 16'd1;
          case (c)
            8'h28: t.kind = 6'd11;
            8'h29: t.kind = 6'd12;
            8'h7b: t.kind = 6'd13;
            8'h7d: t.kind = 6'd14;
            8'h5b: t.kind = 6'd15;
            8'h5d: t.kind = 6'd16;
            8'h2c: t.kind = 6'd17;
            8'h3b: t.kind = 6'd18;
            8'h2b: t.kind = 6'd19;
            8'h2d: t.kind = 6'd20;
            8'h2a: t.kind = 6'd21;
            8'h25: t.kind = 6'd23;
            default: t.kind = KUnknown;
          endcase
          toks[n] = t;
          n = n + 2'd1;
        end
      end

      off_d = (off_q == {OffW{1'b1}}) ? off_q : off_q + 1'b1;
      if (c == 8'h0a) begin
        line_d = (line_q == {LineW{1'b1}}) ? line_q : line_q + 1'b1;
        col_d = 16'd1;
      end else begin
        col_d = (col_q == {ColW{1'b1}}) ? col_q : col_q + 1'b1;
      end
    end

    if (n != 2'd0) toks[n - 2'd1].last = 1'b1;
    bundle_o.count = n;
    bundle_o.tok0 = toks[0];
    bundle_o.tok1 = toks[1];
    bundle_o.tok2 = toks[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; pend_q <= '0;
      line_q <= 24'd1; col_q <= 16'd1; off_q <= '0;
      sline_q <= 24'd1; scol_q <= 16'd1; soff_q <= '0;
      cnt_q <= '0; pref_q <= '0;
    end else begin
      mode_q <= mode_d; pend_q <= pend_d;
      line_q <= line_d; col_q <= col_d; off_q <= off_d;
      sline_q <= sline_d; scol_q <= scol_d; soff_q <= soff_d;
      cnt_q <= cnt_d; pref_q <= pref_d;
    end
  end

endmodule

>>> rtl/clt_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer token queue
// Stores up to three tokens a cycle and releases one a cycle while pop_i is high and it is not empty.
// ----------------------------------------------------------------------------
module clt_queue import clt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  output logic    space_o,
  output logic    valid_o,
  output token_t  token_o,
  input  logic    pop_i
);

`include "c_like_source_tokenizer_core_macros.svh"

  localparam int unsigned Depth = 8;
  localparam int unsigned PtrW = 3;

  token_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic [1:0]      n;
  logic            pop;

  assign n = push_i ? bundle_i.count : 2'd0;
  assign pop = pop_i && valid_o;
  assign valid_o = cnt_q != '0;
  assign token_o = mem_q[rd_q];
  // Room for a full three-token burst without counting this cycle's pop.
  assign space_o = cnt_q <= (PtrW+1)'(Depth - 3);
  assign cnt_d = cnt_q + (PtrW+1)'(n) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (n >= 2'd1) mem_q[wr_q] <= bundle_i.tok0;
    if (n >= 2'd2) mem_q[wr_q + PtrW'(1)] <= bundle_i.tok1;
    if (n == 2'd3) mem_q[wr_q + PtrW'(2)] <= bundle_i.tok2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_q + PtrW'(n);
      rd_q <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  `CLT_ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, cnt_q <= (PtrW+1)'(Depth))
  `CLT_ASSERT_IMPL(a_push_has_room, clk_i, rst_ni, n != 2'd0, space_o)
  `CLT_ASSERT_IMPL(a_empty_no_valid, clk_i, rst_ni, cnt_q == '0, !valid_o)

endmodule
